### design/aesd_pkg.sv
// ----------------------------------------------------------------------------
// AES decrypt package
// Shared constants, the inverse S-box and GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aesd_pkg;

    localparam int NumRounds = 10;
    localparam int KeyWords  = 2 * (NumRounds + 1);
    localparam int KeyIdxW   = $clog2(KeyWords);
    localparam int RndW      = $clog2(NumRounds + 1);

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] tab [256];
        tab = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        return tab[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Multiply by 0x0E, 0x0B, 0x0D, 0x09 via doubling chain.
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] b [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int k = 0; k < 4; k++) begin
            b[k]  = c[31 - 8 * k -: 8];
            x2[k] = xtime(b[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            m9[k] = x8[k] ^ b[k];
            mb[k] = x8[k] ^ x2[k] ^ b[k];
            md[k] = x8[k] ^ x4[k] ^ b[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
        end
        return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

endpackage

### design/aesd_ram.sv
// ----------------------------------------------------------------------------
// AES decrypt generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module aesd_ram #(
    parameter int Width = 64,
    parameter int Depth = 22
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### design/aes_block_decrypt_unit.sv
// ----------------------------------------------------------------------------
// AES-128 block decrypt unit
// Inverse cipher over preloaded round keys, worked in half-round passes.
// ----------------------------------------------------------------------------
// Key words and ciphertext halves share the slave stream. A key word write or
// a first half leaves the block in S_IDLE. A second half starts decryption:
// the state is 128 bits, but the key store gives one 64-bit word per cycle.
// Each round runs as passes: one pass runs InvShiftRows/InvSubBytes over
// the whole state, then two half-round passes each XOR one key word into
// eight bytes and run InvMixColumns on those two columns (no mix in the
// final round). The initial key add runs in S_LOAD and S_ARK, then the
// rounds follow in S_ROUND; tvalid rises after the last half-round pass of
// the final round. The pace is set by the one-word key read port and the
// separate shift/sub pass. Then come two output transfers, the second with
// tlast; after it the block returns to S_IDLE and takes its next item. The
// block takes no item until both halves are delivered.
// ----------------------------------------------------------------------------
module aes_block_decrypt_unit
    import aesd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // key_word_index[4:0], data_word[68:5], zeros
    input  logic [1:0]  s_axis_tuser,   // operation[0], block_half[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // plain_word
    output logic        m_axis_tlast    // last_half
);
    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_ARK, S_ROUND, S_OUT0, S_OUT1
    } t_state;

    t_state            r_state;
    logic [127:0]      r_st;
    logic [63:0]       r_first;
    logic [RndW-1:0]   r_rnd;
    logic              r_half;
    logic              r_first_pass;

    logic [KeyIdxW-1:0] n_raddr;
    logic [63:0]        w_key;

    logic              w_acc;
    logic              w_op;
    logic              w_bh;
    logic [4:0]        w_idx;
    logic [63:0]       w_dat;

    assign w_op  = s_axis_tuser[0];
    assign w_bh  = s_axis_tuser[1];
    assign w_idx = s_axis_tdata[4:0];
    assign w_dat = s_axis_tdata[68:5];
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    aesd_ram #(.Width(64), .Depth(KeyWords)) u_keys (
        .i_clk  (i_clk),
        .i_we   (w_acc && w_op == OP_KEY && w_idx < 5'(KeyWords)),
        .i_waddr(w_idx[KeyIdxW-1:0]),
        .i_wdata(w_dat),
        .i_raddr(n_raddr),
        .o_rdata(w_key)
    );

    // Inverse shift rows plus inverse S-box over the whole state.
    logic [127:0] w_shsub;
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                w_shsub[127 - 8 * (4 * c + r) -: 8] =
                    inv_sbox(r_st[127 - 8 * (4 * ((c - r) & 3) + r) -: 8]);
            end
        end
    end

    // Half-round: key XOR on the half, then mix on both columns of it.
    logic [63:0] w_xk;
    logic [63:0] w_mix;
    assign w_xk  = (r_half ? r_st[63:0] : r_st[127:64]) ^ w_key;
    assign w_mix = {inv_mix_col(w_xk[63:32]), inv_mix_col(w_xk[31:0])};

    // Key word read address: request the word used in the next cycle.
    always_comb begin
        n_raddr = '0;
        case (r_state)
            S_IDLE:  n_raddr = KeyIdxW'(2 * NumRounds);
            S_LOAD:  n_raddr = KeyIdxW'(2 * NumRounds + 1);
            S_ARK:   n_raddr = KeyIdxW'(2 * NumRounds + 1);
            S_ROUND: n_raddr = r_first_pass ? {r_rnd, 1'b0} : {r_rnd, 1'b1};
            default: n_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_first       <= '0;
            m_axis_tvalid <= 1'b0;
            m_axis_tlast  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc && w_op == OP_DATA) begin
                        if (!w_bh) begin
                            r_first <= w_dat;
                        end else begin
                            r_st    <= {r_first, w_dat};
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    // Key word 2*NumRounds is ready now.
                    r_st[127:64] <= r_st[127:64] ^ w_key;
                    r_state      <= S_ARK;
                end
                S_ARK: begin
                    r_st[63:0]   <= r_st[63:0] ^ w_key;
                    r_rnd        <= RndW'(NumRounds - 1);
                    r_half       <= 1'b0;
                    r_first_pass <= 1'b1;
                    r_state      <= S_ROUND;
                end
                S_ROUND: begin
                    if (r_first_pass) begin
                        // Apply shift/sub first; fetch the upper-half key word.
                        r_st         <= w_shsub;
                        r_first_pass <= 1'b0;
                    end else begin
                        if (r_rnd == '0) begin
                            if (!r_half) r_st[127:64] <= w_xk;
                            else         r_st[63:0]   <= w_xk;
                        end else begin
                            if (!r_half) r_st[127:64] <= w_mix;
                            else         r_st[63:0]   <= w_mix;
                        end
                        r_half <= !r_half;
                        if (r_half) begin
                            if (r_rnd == '0) begin
                                m_axis_tvalid <= 1'b1;
                                m_axis_tlast  <= 1'b0;
                                r_state       <= S_OUT0;
                            end else begin
                                r_rnd        <= r_rnd - RndW'(1);
                                r_first_pass <= 1'b1;
                            end
                        end
                    end
                end
                S_OUT0: begin
                    if (m_axis_tready) begin
                        m_axis_tlast <= 1'b1;
                        r_state      <= S_OUT1;
                    end
                end
                S_OUT1: begin
                    if (m_axis_tready) begin
                        m_axis_tvalid <= 1'b0;
                        m_axis_tlast  <= 1'b0;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = m_axis_tlast ? r_st[63:0] : r_st[127:64];

`ifndef NO_ASSERTIONS
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while output pending");
    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("second half missing");
    a_start_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !m_axis_tlast)
        else $error("output began with last half");
`endif
endmodule
